FILE: hdl/hsms_pkg.sv
package hsms_pkg;

   localparam int PhaseWidth = 3;
   localparam logic [PhaseWidth-1:0] PH_LEN  = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_HDR  = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_FMT  = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_ILEN = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_ELEM = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_SKIP = 3'd5;

   localparam logic [2:0] EV_HDR_OK  = 3'd0;
   localparam logic [2:0] EV_HDR_REJ = 3'd1;
   localparam logic [2:0] EV_ITEM    = 3'd2;
   localparam logic [2:0] EV_ELEM    = 3'd3;
   localparam logic [2:0] EV_ERR     = 3'd4;
   localparam logic [2:0] EV_END     = 3'd5;

   localparam logic [3:0] HDR_BYTES   = 4'd10;
   localparam logic [3:0] LEN_BYTES   = 4'd4;
   localparam logic [3:0] SID_BYTES   = 4'd6;
   localparam logic [5:0] FMT_LIST    = 6'o00;
   localparam logic [5:0] FMT_JIS8    = 6'o21;
   localparam logic [5:0] FMT_CHAR2   = 6'o22;
   localparam logic [15:0] SID_ALL    = 16'hFFFF;
   localparam logic [7:0] STYPE_MAX   = 8'd127;

   localparam int RspDepth = 4;
   localparam int RspPtrWidth = 2;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] session_id;
      logic [7:0]  status_two;
      logic [7:0]  status_three;
      logic [7:0]  presentation_type;
      logic [7:0]  session_type;
      logic [31:0] system_bytes;
      logic [5:0]  item_format;
      logic [23:0] item_count;
      logic [4:0]  nest_depth;
      logic [63:0] element_value;
      logic        last_of_run;
   } rsp_type;

   function automatic logic [3:0] elem_size(input logic [5:0] fmt);
      logic [3:0] s;
      case (fmt)
         6'o10, 6'o11, 6'o20, 6'o31, 6'o51: s = 4'd1;
         6'o21, 6'o22, 6'o32, 6'o52:        s = 4'd2;
         6'o34, 6'o44, 6'o54:               s = 4'd4;
         6'o30, 6'o40, 6'o50:               s = 4'd8;
         default:                           s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

FILE: hdl/hsms_parse.sv
module hsms_parse #(
   parameter int MAX_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   output logic [1:0]       out_cnt,
   output hsms_pkg::rsp_type out0,
   output hsms_pkg::rsp_type out1
);

   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [hsms_pkg::PhaseWidth-1:0] phase_ff, phase_in;
   logic [3:0]  fbi_ff, fbi_in;
   logic [31:0] mbl_ff, mbl_in;
   logic [47:0] hs_ff, hs_in;
   logic [31:0] sys_ff, sys_in;
   logic [23:0] ilen_ff, ilen_in;
   logic [1:0]  lbl_ff, lbl_in;
   logic [63:0] eacc_ff, eacc_in;
   logic [3:0]  ebl_ff, ebl_in;
   logic [23:0] el_ff, el_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [5:0]  fmt_ff, fmt_in;
   logic [23:0] cnt_ff, cnt_in;
   logic [LW-1:0] dep_ff, dep_in;
   logic [3:0]  size_ff, size_in;
   logic [23:0] lcs_ff [MAX_DEPTH];
   logic [MAX_DEPTH-1:0] one_ff;

   logic        st_wen;
   logic [IW-1:0] st_widx;
   logic [23:0] st_wdata;

   logic        m_v, t_v;
   logic [2:0]  m_ev, t_ev;
   logic [63:0] m_val;

   function automatic logic hdr_ok(input logic [47:0] hs, input logic data);
      logic [15:0] sid;
      logic [7:0] b2, b3, st;
      logic ok;
      sid = hs[47:32];
      b2  = hs[31:24];
      b3  = hs[23:16];
      st  = hs[7:0];
      case (st)
         8'd0: ok = (b2 != 8'd0);
         8'd1, 8'd3, 8'd9: ok = (b2 == 8'd0) && (b3 == 8'd0) && !data;
         8'd2, 8'd4: ok = (b2 == 8'd0) && !data;
         8'd5, 8'd6: ok = (sid == hsms_pkg::SID_ALL) && (b2 == 8'd0) && (b3 == 8'd0)
                          && !data;
         8'd7: ok = !data;
         8'd8, 8'd10: ok = 1'b0;
         default: ok = (st <= hsms_pkg::STYPE_MAX);
      endcase
      return ok;
   endfunction

   always_comb begin
      logic        last;
      logic        done;
      logic        found;
      logic [IW-1:0] t;
      logic [23:0] top;
      logic [3:0]  sz;
      phase_in = phase_ff;
      fbi_in   = fbi_ff;
      mbl_in   = mbl_ff;
      hs_in    = hs_ff;
      sys_in   = sys_ff;
      ilen_in  = ilen_ff;
      lbl_in   = lbl_ff;
      eacc_in  = eacc_ff;
      ebl_in   = ebl_ff;
      el_in    = el_ff;
      lvl_in   = lvl_ff;
      fmt_in   = fmt_ff;
      cnt_in   = cnt_ff;
      dep_in   = dep_ff;
      size_in  = size_ff;
      st_wen   = 1'b0;
      st_widx  = lvl_ff[IW-1:0];
      st_wdata = cnt_ff;
      m_v = 1'b0; m_ev = hsms_pkg::EV_END; m_val = 64'd0;
      t_v = 1'b0; t_ev = hsms_pkg::EV_END;
      last = 1'b0;
      done = 1'b0;
      found = 1'b0;
      t = '0;
      top = 24'd0;
      sz = 4'd0;
      if (phase_ff == hsms_pkg::PH_LEN) begin
         mbl_in = {mbl_ff[23:0], in_byte};
         fbi_in = fbi_ff + 4'd1;
         if (fbi_in >= hsms_pkg::LEN_BYTES) begin
            fbi_in = 4'd0;
            hs_in = 48'd0;
            sys_in = 32'd0;
            fmt_in = 6'd0; cnt_in = 24'd0; dep_in = '0; size_in = 4'd0;
            ilen_in = 24'd0; lbl_in = 2'd0; eacc_in = 64'd0; ebl_in = 4'd0;
            el_in = 24'd0; lvl_in = '0;
            if (mbl_in < 32'(hsms_pkg::HDR_BYTES)) begin
               m_v = 1'b1; m_ev = hsms_pkg::EV_HDR_REJ;
               if (mbl_in == 32'd0) begin
                  t_v = 1'b1; t_ev = hsms_pkg::EV_END;
                  phase_in = hsms_pkg::PH_LEN;
               end else begin
                  phase_in = hsms_pkg::PH_SKIP;
               end
            end else begin
               phase_in = hsms_pkg::PH_HDR;
            end
         end
      end else begin
         mbl_in = mbl_ff - 32'd1;
         last = (mbl_in == 32'd0);
         case (phase_ff)
            hsms_pkg::PH_HDR: begin
               if (fbi_ff < hsms_pkg::SID_BYTES) begin
                  hs_in = {hs_ff[39:0], in_byte};
               end else begin
                  sys_in = {sys_ff[23:0], in_byte};
               end
               fbi_in = fbi_ff + 4'd1;
               if (fbi_in >= hsms_pkg::HDR_BYTES) begin
                  fbi_in = 4'd0;
                  m_v = 1'b1;
                  m_ev = hdr_ok(hs_in, !last) ? hsms_pkg::EV_HDR_OK : hsms_pkg::EV_HDR_REJ;
                  if (hdr_ok(hs_in, !last) && hs_in[15:0] == 16'd0 && !last) begin
                     phase_in = hsms_pkg::PH_FMT;
                  end else begin
                     phase_in = hsms_pkg::PH_SKIP;
                  end
               end
            end
            hsms_pkg::PH_FMT: begin
               fmt_in = in_byte[7:2];
               size_in = hsms_pkg::elem_size(fmt_in);
               dep_in = lvl_ff;
               cnt_in = 24'd0;
               if (in_byte[1:0] == 2'd0 || (fmt_in != hsms_pkg::FMT_LIST && size_in == 4'd0)) begin
                  m_v = 1'b1; m_ev = hsms_pkg::EV_ERR;
                  phase_in = hsms_pkg::PH_SKIP;
               end else begin
                  lbl_in = in_byte[1:0];
                  ilen_in = 24'd0;
                  phase_in = hsms_pkg::PH_ILEN;
               end
            end
            hsms_pkg::PH_ILEN: begin
               ilen_in = {ilen_ff[15:0], in_byte};
               lbl_in = lbl_ff - 2'd1;
               if (lbl_in == 2'd0) begin
                  sz = size_ff;
                  if (fmt_ff == hsms_pkg::FMT_LIST) begin
                     cnt_in = ilen_in;
                     if (cnt_in == 24'd0) begin
                        m_v = 1'b1; m_ev = hsms_pkg::EV_ITEM;
                        done = 1'b1;
                     end else if (lvl_ff >= LW'(MAX_DEPTH)) begin
                        m_v = 1'b1; m_ev = hsms_pkg::EV_ERR;
                        phase_in = hsms_pkg::PH_SKIP;
                     end else begin
                        m_v = 1'b1; m_ev = hsms_pkg::EV_ITEM;
                        st_wen = 1'b1;
                        st_widx = lvl_ff[IW-1:0];
                        st_wdata = cnt_in;
                        lvl_in = lvl_ff + LW'(1);
                        phase_in = hsms_pkg::PH_FMT;
                     end
                  end else if (sz == 4'd0 || (ilen_in & 24'(sz - 4'd1)) != 24'd0) begin
                     m_v = 1'b1; m_ev = hsms_pkg::EV_ERR;
                     phase_in = hsms_pkg::PH_SKIP;
                  end else begin
                     case (sz)
                        4'd2:    cnt_in = ilen_in >> 1;
                        4'd4:    cnt_in = ilen_in >> 2;
                        4'd8:    cnt_in = ilen_in >> 3;
                        default: cnt_in = ilen_in;
                     endcase
                     if ((fmt_ff == hsms_pkg::FMT_JIS8 || fmt_ff == hsms_pkg::FMT_CHAR2)
                         && cnt_in != 24'd0) begin
                        m_v = 1'b1; m_ev = hsms_pkg::EV_ERR;
                        phase_in = hsms_pkg::PH_SKIP;
                     end else begin
                        m_v = 1'b1; m_ev = hsms_pkg::EV_ITEM;
                        if (cnt_in == 24'd0) begin
                           done = 1'b1;
                        end else begin
                           el_in = cnt_in;
                           ebl_in = sz;
                           eacc_in = 64'd0;
                           phase_in = hsms_pkg::PH_ELEM;
                        end
                     end
                  end
               end
            end
            hsms_pkg::PH_ELEM: begin
               eacc_in = {eacc_ff[55:0], in_byte};
               if (ebl_ff != 4'd0) begin
                  ebl_in = ebl_ff - 4'd1;
               end
               if (ebl_in == 4'd0) begin
                  m_v = 1'b1; m_ev = hsms_pkg::EV_ELEM; m_val = eacc_in;
                  eacc_in = 64'd0;
                  el_in = el_ff - 24'd1;
                  if (el_in == 24'd0) begin
                     done = 1'b1;
                  end else begin
                     ebl_in = size_ff;
                  end
               end
            end
            default: phase_in = hsms_pkg::PH_SKIP;
         endcase
         // Completing an item pops every list whose last child this was and
         // counts down the innermost list that still has children left.
         if (done) begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
               if (LW'(i) < lvl_ff && !one_ff[i]) begin
                  found = 1'b1;
                  t = IW'(i);
               end
            end
            top = lcs_ff[t];
            if (found) begin
               st_wen = 1'b1;
               st_widx = t;
               st_wdata = top - 24'd1;
               lvl_in = LW'(t) + LW'(1);
               phase_in = hsms_pkg::PH_FMT;
            end else begin
               lvl_in = '0;
               phase_in = hsms_pkg::PH_SKIP;
            end
         end
         if (last) begin
            t_v = 1'b1;
            if (phase_in == hsms_pkg::PH_FMT || phase_in == hsms_pkg::PH_ILEN
                || phase_in == hsms_pkg::PH_ELEM) begin
               t_ev = hsms_pkg::EV_ERR;
            end else begin
               t_ev = hsms_pkg::EV_END;
            end
            phase_in = hsms_pkg::PH_LEN;
            fbi_in = 4'd0;
         end
      end
   end

   function automatic hsms_pkg::rsp_type make_rsp(input logic [2:0] ev, input logic [63:0] val,
                                                  input logic lst);
      hsms_pkg::rsp_type r;
      logic item;
      item = (ev == hsms_pkg::EV_ITEM) || (ev == hsms_pkg::EV_ELEM) || (ev == hsms_pkg::EV_ERR);
      r.event_res = ev;
      r.session_id = hs_in[47:32];
      r.status_two = hs_in[31:24];
      r.status_three = hs_in[23:16];
      r.presentation_type = hs_in[15:8];
      r.session_type = hs_in[7:0];
      r.system_bytes = sys_in;
      r.item_format = item ? fmt_in : 6'd0;
      r.item_count = item ? cnt_in : 24'd0;
      r.nest_depth = item ? 5'(dep_in) : 5'd0;
      r.element_value = (ev == hsms_pkg::EV_ELEM) ? val : 64'd0;
      r.last_of_run = lst;
      return r;
   endfunction

   always_comb begin
      out_cnt = 2'(m_v) + 2'(t_v);
      if (m_v) begin
         out0 = make_rsp(m_ev, m_val, !t_v);
      end else begin
         out0 = make_rsp(t_ev, 64'd0, 1'b1);
      end
      out1 = make_rsp(t_ev, 64'd0, 1'b1);
      if (!in_valid) begin
         out_cnt = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hsms_pkg::PH_LEN;
         fbi_ff   <= 4'd0;
         mbl_ff   <= 32'd0;
         hs_ff    <= 48'd0;
         sys_ff   <= 32'd0;
         ilen_ff  <= 24'd0;
         lbl_ff   <= 2'd0;
         eacc_ff  <= 64'd0;
         ebl_ff   <= 4'd0;
         el_ff    <= 24'd0;
         lvl_ff   <= '0;
         fmt_ff   <= 6'd0;
         cnt_ff   <= 24'd0;
         dep_ff   <= '0;
         size_ff  <= 4'd0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         fbi_ff   <= fbi_in;
         mbl_ff   <= mbl_in;
         hs_ff    <= hs_in;
         sys_ff   <= sys_in;
         ilen_ff  <= ilen_in;
         lbl_ff   <= lbl_in;
         eacc_ff  <= eacc_in;
         ebl_ff   <= ebl_in;
         el_ff    <= el_in;
         lvl_ff   <= lvl_in;
         fmt_ff   <= fmt_in;
         cnt_ff   <= cnt_in;
         dep_ff   <= dep_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && st_wen) begin
         lcs_ff[st_widx] <= st_wdata;
         one_ff[st_widx] <= (st_wdata == 24'd1);
      end
   end

`ifndef SYNTH
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LW'(MAX_DEPTH))
      else $error("list stack level beyond its depth");
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= hsms_pkg::PH_SKIP)
      else $error("parser phase out of range");
   a_two_last: assert property (@(posedge clock) disable iff (reset)
      out_cnt == 2'd2 |-> !out0.last_of_run && out1.last_of_run)
      else $error("two results with wrong last marking");
   a_stack_empty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hsms_pkg::PH_LEN |-> $past(in_valid) || $stable(phase_ff))
      else $error("phase changed without an item");
`endif

endmodule

FILE: hdl/hsms_rsp_fifo.sv
module hsms_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_cnt,
   input  hsms_pkg::rsp_type push0,
   input  hsms_pkg::rsp_type push1,
   output logic             room_two,
   output logic             out_valid,
   input  logic             out_ready,
   output hsms_pkg::rsp_type out_data
);

   localparam int PW = hsms_pkg::RspPtrWidth;

   hsms_pkg::rsp_type mem_ff [hsms_pkg::RspDepth];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          pop;

   assign pop = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_data = mem_ff[rd_ff];
   assign room_two = (cnt_ff <= (PW+1)'(hsms_pkg::RspDepth - 2));

   always_comb begin
      wr_in = wr_ff + PW'(push_cnt);
      rd_in = rd_ff + PW'(pop);
      cnt_in = cnt_ff + (PW+1)'(push_cnt) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ff + PW'(1)] <= push1;
      end
   end

endmodule

FILE: hdl/hsms_secs_message_parser_top.sv
// Channel   Direction  Ports                                Contents
// req       in         req_tvalid/tready/tdata              one stream byte per item
// rsp       out        rsp_tvalid/tready/tdata/tuser/tlast  one parse event per item
//
// One byte is taken in every cycle while the response queue has room for two
// items; each byte yields zero, one or two events, registered into the queue.
// The four-item response queue drains one item per cycle while rsp is ready.
// Reset is synchronous and active high and returns the parser to the length
// prefix with an empty queue.
// A stall on rsp backs up into req only once the queue holds more than two.
module hsms_secs_message_parser_top #(
   parameter int MAX_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // in_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // session_id, status_two, status_three, presentation_type, session_type,
   // system_bytes, item_format, item_count, nest_depth, element_value, zero fill
   output logic [183:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // event_res
   output logic         rsp_tlast    // last_of_run
);

   logic              accept;
   logic [1:0]        res_cnt;
   hsms_pkg::rsp_type res0, res1, head;

   assign accept = req_tvalid && req_tready;

   hsms_parse #(.MAX_DEPTH(MAX_DEPTH)) u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_byte  (req_tdata),
      .out_cnt  (res_cnt),
      .out0     (res0),
      .out1     (res1)
   );

   hsms_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (res_cnt),
      .push0     (res0),
      .push1     (res1),
      .room_two  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {5'b00000, head.element_value, head.nest_depth, head.item_count,
                       head.item_format, head.system_bytes, head.session_type,
                       head.presentation_type, head.status_three, head.status_two,
                       head.session_id};
   assign rsp_tuser = head.event_res;
   assign rsp_tlast = head.last_of_run;

endmodule

FILE: test/tb_hsms_secs_message_parser_top.sv
`timescale 1ns / 1ps

module tb_hsms_secs_message_parser_top;

   localparam int StackDepth = 16;
   localparam int CycleLimit = 200000;

   typedef struct {
      logic [7:0] data;
      bit         drain;
   } stream_byte_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   stream_byte_type   stream_q[$];
   logic [7:0]        body[$];
   hsms_pkg::rsp_type event_q[$];

   int errors = 0;
   int bytes_sent = 0;
   int events_seen = 0;
   int messages = 0;
   int cycles = 0;
   bit calm;

   // Parser shadow state.
   logic [2:0]  ph;
   int          fbi;
   logic [31:0] msg_left;
   logic [47:0] hdr;
   logic [31:0] sys;
   logic [23:0] ilen;
   logic [1:0]  len_left;
   logic [63:0] elem_acc;
   logic [3:0]  elem_left_bytes;
   logic [23:0] elems_left;
   logic [23:0] list_stack[StackDepth];
   int          level;
   logic [5:0]  cur_fmt;
   logic [23:0] cur_cnt;
   logic [4:0]  cur_dep;
   logic [3:0]  cur_sz;

   hsms_secs_message_parser_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #6 clock = ~clock;

   function automatic logic [3:0] secs_elem_bytes(logic [5:0] f);
      case (f)
         6'o10, 6'o11, 6'o20, 6'o31, 6'o51: return 4'd1;
         6'o21, 6'o22, 6'o32, 6'o52:        return 4'd2;
         6'o34, 6'o44, 6'o54:               return 4'd4;
         6'o30, 6'o40, 6'o50:               return 4'd8;
         default:                           return 4'd0;
      endcase
   endfunction

   function void push_event(logic [2:0] ev, logic [63:0] value);
      hsms_pkg::rsp_type r;
      bit item;
      item = (ev == hsms_pkg::EV_ITEM || ev == hsms_pkg::EV_ELEM || ev == hsms_pkg::EV_ERR);
      r.event_res = ev;
      r.session_id = hdr[47:32];
      r.status_two = hdr[31:24];
      r.status_three = hdr[23:16];
      r.presentation_type = hdr[15:8];
      r.session_type = hdr[7:0];
      r.system_bytes = sys;
      r.item_format = item ? cur_fmt : 6'd0;
      r.item_count = item ? cur_cnt : 24'd0;
      r.nest_depth = item ? cur_dep : 5'd0;
      r.element_value = (ev == hsms_pkg::EV_ELEM) ? value : 64'd0;
      r.last_of_run = 1'b0;
      event_q.push_back(r);
   endfunction

   function bit header_accepted();
      logic [7:0] st;
      bit data;
      st = hdr[7:0];
      data = (msg_left != 0);
      if (st == 8 || st == 10 || st > hsms_pkg::STYPE_MAX) return 0;
      case (st)
         0:       return hdr[31:24] != 0;
         1, 3, 9: return hdr[31:16] == 0 && !data;
         2, 4:    return hdr[31:24] == 0 && !data;
         5, 6:    return hdr[47:32] == hsms_pkg::SID_ALL && hdr[31:16] == 0 && !data;
         7:       return !data;
         default: return 1;
      endcase
   endfunction

   function void close_item();
      while (level != 0) begin
         list_stack[level-1] = list_stack[level-1] - 1;
         if (list_stack[level-1] != 0) begin
            ph = hsms_pkg::PH_FMT;
            return;
         end
         level--;
      end
      ph = hsms_pkg::PH_SKIP;
   endfunction

   function void clear_item();
      cur_fmt = 0; cur_cnt = 0; cur_dep = 0; cur_sz = 0;
      ilen = 0; len_left = 0; elem_acc = 0; elem_left_bytes = 0; elems_left = 0;
      level = 0;
   endfunction

   function void parse_byte(logic [7:0] b);
      int start;
      bit last;
      hsms_pkg::rsp_type r;
      start = event_q.size();
      if (ph == hsms_pkg::PH_LEN) begin
         msg_left = {msg_left[23:0], b};
         fbi++;
         if (fbi >= 4) begin
            fbi = 0; hdr = 0; sys = 0;
            clear_item();
            if (msg_left < hsms_pkg::HDR_BYTES) begin
               push_event(hsms_pkg::EV_HDR_REJ, 0);
               if (msg_left == 0) begin
                  push_event(hsms_pkg::EV_END, 0);
                  ph = hsms_pkg::PH_LEN;
               end else begin
                  ph = hsms_pkg::PH_SKIP;
               end
            end else begin
               ph = hsms_pkg::PH_HDR;
            end
         end
      end else begin
         msg_left = msg_left - 1;
         last = (msg_left == 0);
         case (ph)
            hsms_pkg::PH_HDR: begin
               if (fbi < hsms_pkg::SID_BYTES) hdr = {hdr[39:0], b};
               else sys = {sys[23:0], b};
               fbi++;
               if (fbi >= hsms_pkg::HDR_BYTES) begin
                  fbi = 0;
                  if (header_accepted()) begin
                     push_event(hsms_pkg::EV_HDR_OK, 0);
                     ph = (hdr[15:0] == 0 && !last) ? hsms_pkg::PH_FMT : hsms_pkg::PH_SKIP;
                  end else begin
                     push_event(hsms_pkg::EV_HDR_REJ, 0);
                     ph = hsms_pkg::PH_SKIP;
                  end
               end
            end
            hsms_pkg::PH_FMT: begin
               cur_fmt = b[7:2];
               cur_sz = secs_elem_bytes(cur_fmt);
               cur_dep = level[4:0];
               cur_cnt = 0;
               if (b[1:0] == 0 || (cur_fmt != hsms_pkg::FMT_LIST && cur_sz == 0)) begin
                  push_event(hsms_pkg::EV_ERR, 0);
                  ph = hsms_pkg::PH_SKIP;
               end else begin
                  len_left = b[1:0];
                  ilen = 0;
                  ph = hsms_pkg::PH_ILEN;
               end
            end
            hsms_pkg::PH_ILEN: begin
               ilen = {ilen[15:0], b};
               len_left = len_left - 1;
               if (len_left == 0) begin
                  if (cur_fmt == hsms_pkg::FMT_LIST) begin
                     cur_cnt = ilen;
                     if (cur_cnt == 0) begin
                        push_event(hsms_pkg::EV_ITEM, 0);
                        close_item();
                     end else if (level >= StackDepth) begin
                        push_event(hsms_pkg::EV_ERR, 0);
                        ph = hsms_pkg::PH_SKIP;
                     end else begin
                        push_event(hsms_pkg::EV_ITEM, 0);
                        list_stack[level] = cur_cnt;
                        level++;
                        ph = hsms_pkg::PH_FMT;
                     end
                  end else if (ilen % cur_sz != 0) begin
                     push_event(hsms_pkg::EV_ERR, 0);
                     ph = hsms_pkg::PH_SKIP;
                  end else begin
                     cur_cnt = ilen / cur_sz;
                     if ((cur_fmt == hsms_pkg::FMT_JIS8 || cur_fmt == hsms_pkg::FMT_CHAR2)
                         && cur_cnt != 0) begin
                        push_event(hsms_pkg::EV_ERR, 0);
                        ph = hsms_pkg::PH_SKIP;
                     end else begin
                        push_event(hsms_pkg::EV_ITEM, 0);
                        if (cur_cnt == 0) begin
                           close_item();
                        end else begin
                           elems_left = cur_cnt;
                           elem_left_bytes = cur_sz;
                           elem_acc = 0;
                           ph = hsms_pkg::PH_ELEM;
                        end
                     end
                  end
               end
            end
            hsms_pkg::PH_ELEM: begin
               elem_acc = {elem_acc[55:0], b};
               if (elem_left_bytes != 0) elem_left_bytes--;
               if (elem_left_bytes == 0) begin
                  push_event(hsms_pkg::EV_ELEM, elem_acc);
                  elem_acc = 0;
                  elems_left = elems_left - 1;
                  if (elems_left == 0) close_item();
                  else elem_left_bytes = cur_sz;
               end
            end
            default: ph = hsms_pkg::PH_SKIP;
         endcase
         if (last) begin
            if (ph == hsms_pkg::PH_FMT || ph == hsms_pkg::PH_ILEN || ph == hsms_pkg::PH_ELEM)
               push_event(hsms_pkg::EV_ERR, 0);
            else
               push_event(hsms_pkg::EV_END, 0);
            ph = hsms_pkg::PH_LEN;
            fbi = 0;
         end
      end
      if (event_q.size() > start) begin
         r = event_q.pop_back();
         r.last_of_run = 1'b1;
         event_q.push_back(r);
      end
   endfunction

   task automatic put_item_hdr(logic [5:0] f, int len, int nlb);
      body.push_back({f, nlb[1:0]});
      for (int i = nlb - 1; i >= 0; i--) body.push_back(len[8*i +: 8]);
   endtask

   task automatic gen_item(int depth);
      int r, n, nlb, len;
      logic [5:0] f;
      logic [5:0] good[13];
      logic [3:0] sz;
      good = '{6'o10, 6'o11, 6'o20, 6'o31, 6'o51, 6'o32, 6'o52,
               6'o34, 6'o44, 6'o54, 6'o30, 6'o40, 6'o50};
      r = $urandom_range(0, 99);
      nlb = $urandom_range(1, 3);
      if (r < 30 && depth < 4) begin
         n = $urandom_range(0, 3);
         put_item_hdr(hsms_pkg::FMT_LIST, n, nlb);
         for (int i = 0; i < n; i++) gen_item(depth + 1);
      end else if (r < 95) begin
         f = good[$urandom_range(0, 12)];
         sz = secs_elem_bytes(f);
         len = $urandom_range(0, 3) * sz;
         if (r >= 91 && sz > 1) len++;
         put_item_hdr(f, len, nlb);
         for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 3))
            0: put_item_hdr(($urandom_range(0, 1) != 0) ? hsms_pkg::FMT_JIS8
                                                        : hsms_pkg::FMT_CHAR2,
                            2 * $urandom_range(0, 1), nlb);
            1: body.push_back({6'o01, 2'd1});
            2: body.push_back({6'o20, 2'd0});
            default: body.push_back({6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))});
         endcase
      end
   endtask

   task automatic put_byte(logic [7:0] b, bit drain);
      stream_byte_type s;
      s.data = b;
      s.drain = drain;
      stream_q.push_back(s);
   endtask

   // Frames the current body behind a header; extra > 0 adds trailing bytes and
   // extra < 0 cuts the body short.
   task automatic add_msg(logic [15:0] sid, logic [7:0] b2, logic [7:0] b3,
                          logic [7:0] pt, logic [7:0] st, int extra, bit drain);
      logic [31:0] len;
      logic [31:0] sb;
      for (int i = 0; i < extra; i++) body.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i > extra && body.size() > 0; i--) void'(body.pop_back());
      len = 32'(10 + body.size());
      sb = $urandom;
      for (int i = 3; i >= 0; i--) put_byte(len[8*i +: 8], drain && i == 3);
      put_byte(sid[15:8], 0); put_byte(sid[7:0], 0);
      put_byte(b2, 0); put_byte(b3, 0); put_byte(pt, 0); put_byte(st, 0);
      for (int i = 3; i >= 0; i--) put_byte(sb[8*i +: 8], 0);
      foreach (body[i]) put_byte(body[i], 0);
      body.delete();
      messages++;
   endtask

   task automatic add_short(logic [31:0] len);
      for (int i = 3; i >= 0; i--) put_byte(len[8*i +: 8], 0);
      for (int i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)), 0);
      messages++;
   endtask

   function logic [7:0] data_status();
      return {1'($urandom_range(0, 1)), 7'($urandom_range(1, 127))};
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout with %0d bytes and %0d events outstanding",
                  $time, stream_q.size(), event_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   int send_gap = 0;
   always @(posedge clock) begin
      bit v;
      if (reset) begin
         req_tvalid <= 1'b0;
         ph = hsms_pkg::PH_LEN; fbi = 0; msg_left = 0; hdr = 0; sys = 0;
         clear_item();
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(stream_q[0].data);
            void'(stream_q.pop_front());
            bytes_sent++;
         end
         calm = stream_q.size() < 150;
         if (req_tvalid && !req_tready) begin
            v = 1;
         end else if (send_gap > 0) begin
            send_gap--;
            v = 0;
         end else if (stream_q.size() == 0) begin
            v = 0;
         end else if (stream_q[0].drain && event_q.size() != 0) begin
            v = 0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 2);
            v = 0;
         end else begin
            v = 1;
         end
         req_tvalid <= v;
         if (v) req_tdata <= stream_q[0].data;
      end
   end

   task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   int hold = 0;
   int rsp_gap = 0;
   bit held = 0;
   always @(posedge clock) begin
      hsms_pkg::rsp_type e;
      bit r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            events_seen++;
            if (event_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0h %0h",
                        $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               e = event_q.pop_front();
               check_field("event_res", 64'(e.event_res), 64'(rsp_tuser));
               check_field("session_id", 64'(e.session_id), 64'(rsp_tdata[15:0]));
               check_field("status_two", 64'(e.status_two), 64'(rsp_tdata[23:16]));
               check_field("status_three", 64'(e.status_three), 64'(rsp_tdata[31:24]));
               check_field("presentation_type", 64'(e.presentation_type),
                           64'(rsp_tdata[39:32]));
               check_field("session_type", 64'(e.session_type), 64'(rsp_tdata[47:40]));
               check_field("system_bytes", 64'(e.system_bytes), 64'(rsp_tdata[79:48]));
               check_field("item_format", 64'(e.item_format), 64'(rsp_tdata[85:80]));
               check_field("item_count", 64'(e.item_count), 64'(rsp_tdata[109:86]));
               check_field("nest_depth", 64'(e.nest_depth), 64'(rsp_tdata[114:110]));
               check_field("element_value", e.element_value, rsp_tdata[178:115]);
               check_field("last_of_run", 64'(e.last_of_run), 64'(rsp_tlast));
            end
         end
         if (hold > 0) begin
            hold--;
            r = 0;
         end else if (!held && bytes_sent >= 400) begin
            held = 1;
            hold = 300;
            r = 0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            r = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 2);
            r = 0;
         end else begin
            r = 1;
         end
         rsp_tready <= r;
      end
   end

   initial begin
      logic [7:0] stypes[16];
      int extra;
      reset = 1;

      add_short(0);
      add_short(5);
      stypes = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 127, 128, 255, 0, 0};
      for (int i = 0; i < 14; i++) add_msg(hsms_pkg::SID_ALL, 0, 0, 0, stypes[i], 0, 0);
      add_msg(16'h1234, 0, 0, 0, 5, 0, 0);
      body.push_back(8'hA5);
      add_msg(16'h0001, 0, 0, 0, 7, 0, 0);
      add_msg(16'h0001, 0, 3, 0, 0, 0, 0);
      add_msg(16'h0001, 8'h81, 3, 0, 0, 0, 0);
      body.push_back(8'h01);
      add_msg(16'h0001, 8'h81, 3, 8'h01, 0, 0, 0);
      put_item_hdr(hsms_pkg::FMT_LIST, 13, 1);
      foreach (stypes[i]) stypes[i] = 0;
      begin
         logic [5:0] all_fmt[13];
         all_fmt = '{6'o10, 6'o11, 6'o20, 6'o31, 6'o51, 6'o32, 6'o52,
                     6'o34, 6'o44, 6'o54, 6'o30, 6'o40, 6'o50};
         foreach (all_fmt[i]) begin
            put_item_hdr(all_fmt[i], secs_elem_bytes(all_fmt[i]), 1);
            for (int k = 0; k < secs_elem_bytes(all_fmt[i]); k++)
               body.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
         end
      end
      add_msg(16'hFFFF, 8'hFF, 8'hFF, 0, 0, 0, 1);
      for (int i = 0; i < 17; i++) put_item_hdr(hsms_pkg::FMT_LIST, 1, 1);
      put_item_hdr(6'o10, 0, 1);
      add_msg(16'h0002, 8'h01, 0, 0, 0, 0, 0);
      put_item_hdr(hsms_pkg::FMT_LIST, 2, 3);
      put_item_hdr(hsms_pkg::FMT_JIS8, 0, 2);
      put_item_hdr(hsms_pkg::FMT_CHAR2, 0, 1);
      add_msg(16'h0003, 8'h02, 1, 0, 0, 3, 0);
      put_item_hdr(hsms_pkg::FMT_JIS8, 2, 1);
      add_msg(16'h0004, 8'h02, 1, 0, 0, 0, 0);
      body.push_back({6'o20, 2'd0});
      add_msg(16'h0004, 8'h02, 1, 0, 0, 0, 0);
      body.push_back({6'o77, 2'd1});
      add_msg(16'h0004, 8'h02, 1, 0, 0, 0, 0);
      put_item_hdr(6'o32, 3, 1);
      add_msg(16'h0004, 8'h02, 1, 0, 0, 0, 0);
      put_item_hdr(6'o54, 8, 2);
      for (int k = 0; k < 8; k++) body.push_back(8'h5A);
      add_msg(16'h0005, 8'h7F, 1, 0, 0, -2, 0);

      while (stream_q.size() < 1130) begin
         if ($urandom_range(0, 99) < 78) begin
            gen_item(0);
            extra = 0;
            case ($urandom_range(0, 9))
               0: extra = $urandom_range(1, 3);
               1: extra = -$urandom_range(1, 2);
               default: extra = 0;
            endcase
            add_msg(16'($urandom), data_status(), 8'($urandom), 0, 0, extra,
                    $urandom_range(0, 30) == 0);
         end else if ($urandom_range(0, 3) == 0) begin
            add_short($urandom_range(0, 9));
         end else begin
            for (int k = $urandom_range(0, 6); k > 0; k--) body.push_back(8'($urandom));
            add_msg(16'($urandom), 8'($urandom), 8'($urandom),
                    8'(($urandom_range(0, 3) == 0) ? 0 : $urandom),
                    8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 12) : $urandom),
                    0, 0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (stream_q.size() != 0 || event_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Streamed %0d bytes in %0d messages and checked %0d parse events,",
               bytes_sent, messages, events_seen);
      $display("including header rules, nested lists, bad items and truncation.");
      if (errors == 0 && event_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/hsms_pkg.sv
hdl/hsms_parse.sv
hdl/hsms_rsp_fifo.sv
hdl/hsms_secs_message_parser_top.sv
test/tb_hsms_secs_message_parser_top.sv
